/* rtl/core/lptws_pkg.sv */
package lptws_pkg;

   localparam int MAX_JOBS      = 32;
   localparam int MAX_WINDOWS   = 8;
   localparam int DURATION_BITS = 12;

   localparam int JOB_IDX_W = $clog2(MAX_JOBS);
   localparam int JOB_CNT_W = $clog2(MAX_JOBS + 1);
   localparam int WIN_IDX_W = $clog2(MAX_WINDOWS);
   localparam int WIN_CNT_W = $clog2(MAX_WINDOWS + 1);
   localparam int CFG_W     = 4;
   localparam int STATUS_W  = 3;
   localparam int TICKET_W  = 6;
   localparam int WINDOW_W  = 3;
   localparam int LOAD_W    = 17;
   localparam int UPC_W     = 4;

   typedef enum logic [0:0] {
      REQ_ENQUEUE    = 1'b0,
      REQ_DISTRIBUTE = 1'b1
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_TICKET = 3'd0,
      ST_ZERO   = 3'd1,
      ST_FULL   = 3'd2,
      ST_ASSIGN = 3'd3,
      ST_EMPTY  = 3'd4
   } status_type;

   // Jump conditions evaluated by the sequencer.
   typedef enum logic [2:0] {
      CND_NONE,
      CND_ALWAYS,
      CND_NO_REQ,
      CND_IS_ENQ,
      CND_NO_JOBS,
      CND_JOB_MORE,
      CND_WIN_MORE,
      CND_STEP_MORE
   } cond_type;

   // Datapath operations selected by the control word.
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_DIST_INIT,
      OP_JOB_INIT,
      OP_JOB_SCAN,
      OP_WIN_INIT,
      OP_WIN_SCAN,
      OP_ASSIGN,
      OP_CLEAR,
      OP_ENQ,
      OP_EMPTY
   } op_type;

   typedef logic [UPC_W-1:0] upc_type;

   typedef struct packed {
      cond_type cond;
      upc_type  target;
      op_type   op;
      logic     wait_out;
   } ctrl_word_type;

   localparam upc_type UPC_IDLE     = 4'd0;
   localparam upc_type UPC_DECODE   = 4'd1;
   localparam upc_type UPC_DIST     = 4'd2;
   localparam upc_type UPC_JOB_INIT = 4'd3;
   localparam upc_type UPC_JOB_SCAN = 4'd4;
   localparam upc_type UPC_WIN_INIT = 4'd5;
   localparam upc_type UPC_WIN_SCAN = 4'd6;
   localparam upc_type UPC_ASSIGN   = 4'd7;
   localparam upc_type UPC_CLEAR    = 4'd8;
   localparam upc_type UPC_ENQ      = 4'd9;
   localparam upc_type UPC_EMPTY    = 4'd10;

   // Microprogram: one control word per step.
   function automatic ctrl_word_type ucode_rom(upc_type upc);
      ctrl_word_type w;
      w = '{cond: CND_ALWAYS, target: UPC_IDLE, op: OP_NOP, wait_out: 1'b0};
      case (upc)
         UPC_IDLE:     w = '{CND_NO_REQ,    UPC_IDLE,     OP_LATCH,     1'b0};
         UPC_DECODE:   w = '{CND_IS_ENQ,    UPC_ENQ,      OP_NOP,       1'b0};
         UPC_DIST:     w = '{CND_NO_JOBS,   UPC_EMPTY,    OP_DIST_INIT, 1'b0};
         UPC_JOB_INIT: w = '{CND_NONE,      UPC_IDLE,     OP_JOB_INIT,  1'b0};
         UPC_JOB_SCAN: w = '{CND_JOB_MORE,  UPC_JOB_SCAN, OP_JOB_SCAN,  1'b0};
         UPC_WIN_INIT: w = '{CND_NONE,      UPC_IDLE,     OP_WIN_INIT,  1'b0};
         UPC_WIN_SCAN: w = '{CND_WIN_MORE,  UPC_WIN_SCAN, OP_WIN_SCAN,  1'b0};
         UPC_ASSIGN:   w = '{CND_STEP_MORE, UPC_JOB_INIT, OP_ASSIGN,    1'b1};
         UPC_CLEAR:    w = '{CND_ALWAYS,    UPC_IDLE,     OP_CLEAR,     1'b0};
         UPC_ENQ:      w = '{CND_ALWAYS,    UPC_IDLE,     OP_ENQ,       1'b1};
         UPC_EMPTY:    w = '{CND_ALWAYS,    UPC_IDLE,     OP_EMPTY,     1'b1};
         default:      w = '{CND_ALWAYS,    UPC_IDLE,     OP_NOP,       1'b0};
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/lptws_if.sv */
interface lptws_req_if import lptws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [DURATION_BITS-1:0] duration;

   modport source (output valid, output req_type, output duration, input ready);
   modport sink   (input valid, input req_type, input duration, output ready);
endinterface

interface lptws_rsp_if import lptws_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TICKET_W-1:0] ticket;
   logic [WINDOW_W-1:0] window;
   logic [LOAD_W-1:0]   window_load;
   logic                last;

   modport source (output valid, output status, output ticket, output window,
                   output window_load, output last, input ready);
   modport sink   (input valid, input status, input ticket, input window,
                   input window_load, input last, output ready);
endinterface

/* rtl/core/lpt_job_to_window_scheduler_core.sv */
// Enqueue: fetch, decode and an issue step that loads the output register.
// Distribute of n jobs over w windows: setup, then per job a maximum scan (one
// memory read per job), a minimum scan (one window per cycle) and an assign step,
// then a clear step, or an empty result if there are no jobs; a new request is taken
// after that. A result waiting in the output register stalls only the next issue
// step. Synchronous reset clears the job count, used flags, loads and output valid.
module lpt_job_to_window_scheduler_core import lptws_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   lptws_req_if.sink        req,
   lptws_rsp_if.source      rsp,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   ctrl_word_type ctrl;
   upc_type       upc_ff, upc_in;

   logic                     req_type_ff;
   logic [DURATION_BITS-1:0] dur_ff;
   logic [CFG_W-1:0]         nw_ff;
   logic [CFG_W-1:0]         nw_eff;

   logic [DURATION_BITS-1:0] job_mem [MAX_JOBS];
   logic [DURATION_BITS-1:0] mem_q_ff;
   logic [JOB_IDX_W-1:0]     rd_addr;

   logic [JOB_CNT_W-1:0]     job_count_ff;
   logic [MAX_JOBS-1:0]      used_ff;
   logic [JOB_CNT_W-1:0]     j_ff;
   logic [JOB_IDX_W-1:0]     jq_ff;
   logic [JOB_IDX_W-1:0]     best_idx_ff;
   logic [DURATION_BITS-1:0] best_val_ff;
   logic                     found_ff;
   logic [JOB_CNT_W-1:0]     step_ff;

   logic [LOAD_W-1:0]        totals_ff [MAX_WINDOWS];
   logic [WIN_CNT_W-1:0]     w_ff;
   logic [WIN_IDX_W-1:0]     wmin_ff;
   logic [LOAD_W-1:0]        min_val_ff;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [TICKET_W-1:0]      rsp_ticket_ff;
   logic [WINDOW_W-1:0]      rsp_window_ff;
   logic [LOAD_W-1:0]        rsp_load_ff;
   logic                     rsp_last_ff;

   logic                     out_busy, stall, cond_true, fire, issue;
   logic                     job_more, win_more, step_more, take_job;
   logic [LOAD_W:0]          sum;
   logic [LOAD_W-1:0]        sum_sat;
   logic [LOAD_W-1:0]        win_rd;

   assign ctrl = ucode_rom(upc_ff);

   assign nw_eff = (nw_ff == '0) ? CFG_W'(1) :
                   (nw_ff > CFG_W'(MAX_WINDOWS)) ? CFG_W'(MAX_WINDOWS) : nw_ff;

   assign out_busy  = rsp_valid_ff && !rsp.ready;
   assign stall     = ctrl.wait_out && out_busy;
   assign fire      = !stall;
   // Every step that waits on the output register also loads it.
   assign issue     = ctrl.wait_out && fire;

   assign job_more  = {1'b0, jq_ff} != JOB_CNT_W'(job_count_ff - 1'b1);
   assign win_more  = WIN_CNT_W'(w_ff) < WIN_CNT_W'(nw_eff);
   assign step_more = JOB_CNT_W'(step_ff + 1'b1) != job_count_ff;
   assign win_rd    = totals_ff[w_ff[WIN_IDX_W-1:0]];
   assign take_job  = !used_ff[jq_ff] && (!found_ff || (mem_q_ff > best_val_ff));
   assign sum       = {1'b0, min_val_ff} + (LOAD_W + 1)'(best_val_ff);
   assign sum_sat   = sum[LOAD_W] ? {LOAD_W{1'b1}} : sum[LOAD_W-1:0];
   assign rd_addr   = (ctrl.op == OP_JOB_INIT) ? '0 : j_ff[JOB_IDX_W-1:0];

   always_comb begin
      case (ctrl.cond)
         CND_NONE:      cond_true = 1'b0;
         CND_ALWAYS:    cond_true = 1'b1;
         CND_NO_REQ:    cond_true = !req.valid;
         CND_IS_ENQ:    cond_true = (req_type_ff == REQ_ENQUEUE);
         CND_NO_JOBS:   cond_true = (job_count_ff == '0);
         CND_JOB_MORE:  cond_true = job_more;
         CND_WIN_MORE:  cond_true = win_more;
         CND_STEP_MORE: cond_true = step_more;
         default:       cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (stall) begin
         upc_in = upc_ff;
      end else if (cond_true) begin
         upc_in = ctrl.target;
      end else begin
         upc_in = UPC_W'(upc_ff + 1'b1);
      end
   end

   assign req.ready       = (upc_ff == UPC_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.ticket      = rsp_ticket_ff;
   assign rsp.window      = rsp_window_ff;
   assign rsp.window_load = rsp_load_ff;
   assign rsp.last        = rsp_last_ff;

   // Job store: one write port for enqueue, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_ENQ && fire && dur_ff != '0 &&
          job_count_ff < JOB_CNT_W'(MAX_JOBS)) begin
         job_mem[job_count_ff[JOB_IDX_W-1:0]] <= dur_ff;
      end
      mem_q_ff <= job_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_IDLE;
         nw_ff        <= CFG_W'(1);
         job_count_ff <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            totals_ff[i] <= '0;
         end
      end else begin
         upc_ff <= upc_in;
         if (csr_wr_en) begin
            nw_ff <= csr_wr_data;
         end
         if (issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (ctrl.op)
            OP_LATCH: begin
               req_type_ff <= req.req_type;
               dur_ff      <= req.duration;
            end
            OP_DIST_INIT: begin
               step_ff <= '0;
            end
            OP_JOB_INIT: begin
               j_ff     <= JOB_CNT_W'(1);
               jq_ff    <= '0;
               found_ff <= 1'b0;
            end
            OP_JOB_SCAN: begin
               if (take_job) begin
                  best_idx_ff <= jq_ff;
                  best_val_ff <= mem_q_ff;
                  found_ff    <= 1'b1;
               end
               jq_ff <= j_ff[JOB_IDX_W-1:0];
               j_ff  <= JOB_CNT_W'(j_ff + 1'b1);
            end
            OP_WIN_INIT: begin
               used_ff[best_idx_ff] <= 1'b1;
               w_ff       <= WIN_CNT_W'(1);
               wmin_ff    <= '0;
               min_val_ff <= totals_ff[0];
            end
            OP_WIN_SCAN: begin
               if (win_more) begin
                  if (win_rd < min_val_ff) begin
                     min_val_ff <= win_rd;
                     wmin_ff    <= w_ff[WIN_IDX_W-1:0];
                  end
                  w_ff <= WIN_CNT_W'(w_ff + 1'b1);
               end
            end
            OP_ASSIGN: begin
               if (fire) begin
                  totals_ff[wmin_ff] <= sum_sat;
                  step_ff            <= JOB_CNT_W'(step_ff + 1'b1);
                  rsp_status_ff      <= ST_ASSIGN;
                  rsp_ticket_ff      <= TICKET_W'(best_idx_ff) + TICKET_W'(1);
                  rsp_window_ff      <= WINDOW_W'(wmin_ff);
                  rsp_load_ff        <= sum_sat;
                  rsp_last_ff        <= !step_more;
               end
            end
            OP_CLEAR: begin
               job_count_ff <= '0;
               used_ff      <= '0;
               for (int i = 0; i < MAX_WINDOWS; i++) begin
                  totals_ff[i] <= '0;
               end
            end
            OP_ENQ: begin
               if (fire) begin
                  rsp_window_ff <= '0;
                  rsp_load_ff   <= '0;
                  rsp_last_ff   <= 1'b1;
                  // A zero duration is rejected before the full check.
                  if (dur_ff == '0) begin
                     rsp_status_ff <= ST_ZERO;
                     rsp_ticket_ff <= '0;
                  end else if (job_count_ff >= JOB_CNT_W'(MAX_JOBS)) begin
                     rsp_status_ff <= ST_FULL;
                     rsp_ticket_ff <= '0;
                  end else begin
                     job_count_ff  <= JOB_CNT_W'(job_count_ff + 1'b1);
                     rsp_status_ff <= ST_TICKET;
                     rsp_ticket_ff <= TICKET_W'(job_count_ff) + TICKET_W'(1);
                  end
               end
            end
            OP_EMPTY: begin
               if (fire) begin
                  rsp_status_ff <= ST_EMPTY;
                  rsp_ticket_ff <= '0;
                  rsp_window_ff <= '0;
                  rsp_load_ff   <= '0;
                  rsp_last_ff   <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
